// File: rtl/core/dotq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer queue package
// Shared constants, result status codes and the cell command and status types
// of the deadline ordered timer queue.
// ----------------------------------------------------------------------------
package dotq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int MAX_RESULTS   = 16;
  localparam int HANDLE_BITS   = 16;
  localparam int ACTION_BITS   = 8;
  localparam int STATUS_BITS   = 2;
  localparam int FIRED_DL_BITS = 32;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FIRED    = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_t;

  // What a cell tells its neighbours about itself.
  typedef struct packed {
    logic valid;  // the cell holds an entry
    logic gt;     // its deadline is later than the broadcast key
    logic due;    // its deadline is at or before the broadcast key
  } cell_stat_t;

endpackage : dotq_pkg
`default_nettype wire

// File: rtl/core/dotq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer queue cell
// One slot of the sorted chain: compares its deadline with the broadcast key,
// takes a new entry, shifts from its left neighbour or pulls from its right.
// ----------------------------------------------------------------------------
module dotq_cell
  import dotq_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  cell_op_t               op,
  input  wire  [TIME_BITS-1:0]   key,
  input  wire  [HANDLE_BITS-1:0] new_handle,
  input  wire  [ACTION_BITS-1:0] new_action,
  input  cell_stat_t             left_stat,
  input  wire  [TIME_BITS-1:0]   left_dl,
  input  wire  [HANDLE_BITS-1:0] left_handle,
  input  wire  [ACTION_BITS-1:0] left_action,
  input  cell_stat_t             right_stat,
  input  wire  [TIME_BITS-1:0]   right_dl,
  input  wire  [HANDLE_BITS-1:0] right_handle,
  input  wire  [ACTION_BITS-1:0] right_action,
  output cell_stat_t             stat,
  output logic [TIME_BITS-1:0]   dl,
  output logic [HANDLE_BITS-1:0] handle,
  output logic [ACTION_BITS-1:0] action
);

  logic                   valid_r, valid_nxt;
  logic [TIME_BITS-1:0]   dl_r, dl_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [ACTION_BITS-1:0] action_r, action_nxt;
  logic                   later;

  always_comb begin
    later      = dl_r > key;
    stat.valid = valid_r;
    stat.gt    = valid_r && later;
    stat.due   = valid_r && !later;
  end

  always_comb begin
    valid_nxt  = valid_r;
    dl_nxt     = dl_r;
    handle_nxt = handle_r;
    action_nxt = action_r;
    case (op)
      OP_INSERT: begin
        if (left_stat.gt) begin
          valid_nxt  = 1'b1;
          dl_nxt     = left_dl;
          handle_nxt = left_handle;
          action_nxt = left_action;
        end else if (left_stat.valid && (!valid_r || later)) begin
          // First slot whose entry is later than the new one, or the first free one.
          valid_nxt  = 1'b1;
          dl_nxt     = key;
          handle_nxt = new_handle;
          action_nxt = new_action;
        end
      end
      OP_POP: begin
        valid_nxt  = right_stat.valid;
        dl_nxt     = right_dl;
        handle_nxt = right_handle;
        action_nxt = right_action;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r     <= dl_nxt;
    handle_r <= handle_nxt;
    action_r <= action_nxt;
  end

  assign dl     = dl_r;
  assign handle = handle_r;
  assign action = action_r;

endmodule : dotq_cell
`default_nettype wire

// File: rtl/core/deadline_ordered_timer_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deadline ordered timer queue
// Sorted chain of DEPTH timer cells with insert and expire requests on a
// stream interface.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH timer entries in a chain of cells kept sorted by
// deadline, earliest at the head; entries with equal deadlines keep their
// arrival order. An insert request (in_tuser mode 0) is placed by every cell
// comparing its own deadline with the new one, and gives one result:
// inserted, or queue full when the last cell is occupied. An expire request
// (mode 1) is accepted in the idle state and then pops the head cell once per
// cycle while the output register is free and the head deadline is at or
// before the given time; a request with nothing due gives no result. At most
// MAX_RESULTS entries fire per request and out_tlast marks the final one.
// A request is accepted while the previous result is still waiting, provided
// the output register frees in that cycle. Time values use the low TIME_BITS
// bits and compare as plain unsigned numbers.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_queue
  import dotq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire                                         clk,
  input  wire                                         rst_n,
  input  wire                                         in_tvalid,
  output logic                                        in_tready,
  // Fields from bit 0: deadline, handle, action, current_time, zero fill.
  input  wire  [((2*TIME_BITS+HANDLE_BITS+ACTION_BITS+7)/8)*8-1:0] in_tdata,
  // Fields from bit 0: mode.
  input  wire  [0:0]                                  in_tuser,
  output logic                                        out_tvalid,
  input  wire                                         out_tready,
  // Fields from bit 0: fired_handle, fired_action, fired_deadline, zero fill.
  output logic [((FIRED_DL_BITS+HANDLE_BITS+ACTION_BITS+7)/8)*8-1:0] out_tdata,
  // Fields from bit 0: status.
  output logic [STATUS_BITS-1:0]                      out_tuser,
  output logic                                        out_tlast
);

  localparam int OUT_W  = ((FIRED_DL_BITS+HANDLE_BITS+ACTION_BITS+7)/8)*8;
  localparam int HND_LO = TIME_BITS;
  localparam int ACT_LO = TIME_BITS + HANDLE_BITS;
  localparam int NOW_LO = TIME_BITS + HANDLE_BITS + ACTION_BITS;
  localparam int CNT_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_EXPIRE = 2'b10
  } state_t;

  // Input field views.
  logic                   in_mode;
  logic [TIME_BITS-1:0]   in_deadline;
  logic [HANDLE_BITS-1:0] in_handle;
  logic [ACTION_BITS-1:0] in_action;
  logic [TIME_BITS-1:0]   in_now;

  assign in_mode     = in_tuser[0];
  assign in_deadline = in_tdata[TIME_BITS-1:0];
  assign in_handle   = in_tdata[HND_LO +: HANDLE_BITS];
  assign in_action   = in_tdata[ACT_LO +: ACTION_BITS];
  assign in_now      = in_tdata[NOW_LO +: TIME_BITS];

  // Control and output registers.
  state_t                   state_r, state_nxt;
  logic [TIME_BITS-1:0]     now_r, now_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [HANDLE_BITS-1:0]   out_handle_r, out_handle_nxt;
  logic [ACTION_BITS-1:0]   out_action_r, out_action_nxt;
  logic [FIRED_DL_BITS-1:0] out_dl_r, out_dl_nxt;
  logic                     out_last_r, out_last_nxt;

  // Chain wiring; index 0 is the boundary left of the head and DEPTH+1 the
  // boundary right of the tail.
  cell_stat_t             stat   [DEPTH+2];
  logic [TIME_BITS-1:0]   dl     [DEPTH+2];
  logic [HANDLE_BITS-1:0] handle [DEPTH+2];
  logic [ACTION_BITS-1:0] action [DEPTH+2];

  cell_op_t               op;
  logic [TIME_BITS-1:0]   key;
  logic                   slot_free;
  logic                   in_acc;
  logic                   full;
  logic                   last_fire;
  logic [63:0]            head_dl_ext;

  // The boundary left of the head looks like an occupied, earlier entry so
  // that the head cell can take a new entry; the right boundary is empty.
  assign stat[0]         = '{valid: 1'b1, gt: 1'b0, due: 1'b0};
  assign dl[0]           = '0;
  assign handle[0]       = '0;
  assign action[0]       = '0;
  assign stat[DEPTH+1]   = '{valid: 1'b0, gt: 1'b0, due: 1'b0};
  assign dl[DEPTH+1]     = '0;
  assign handle[DEPTH+1] = '0;
  assign action[DEPTH+1] = '0;

  for (genvar g = 1; g <= DEPTH; g++) begin : g_cell
    dotq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .op           (op),
      .key          (key),
      .new_handle   (in_handle),
      .new_action   (in_action),
      .left_stat    (stat[g-1]),
      .left_dl      (dl[g-1]),
      .left_handle  (handle[g-1]),
      .left_action  (action[g-1]),
      .right_stat   (stat[g+1]),
      .right_dl     (dl[g+1]),
      .right_handle (handle[g+1]),
      .right_action (action[g+1]),
      .stat         (stat[g]),
      .dl           (dl[g]),
      .handle       (handle[g]),
      .action       (action[g])
    );
  end

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;
  assign full      = stat[DEPTH].valid;
  // The head fires last when the entry behind it is not due or the per
  // request limit is reached.
  assign last_fire = !stat[2].due || (cnt_r == CNT_W'(MAX_RESULTS - 1));
  assign head_dl_ext = 64'(dl[1]);
  assign key = (state_r == S_EXPIRE) ? now_r : in_deadline;

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    cnt_nxt        = cnt_r;
    op             = OP_HOLD;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_action_nxt = out_action_r;
    out_dl_nxt     = out_dl_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode) begin
            now_nxt   = in_now;
            cnt_nxt   = '0;
            state_nxt = S_EXPIRE;
          end else begin
            op             = full ? OP_HOLD : OP_INSERT;
            out_valid_nxt  = 1'b1;
            out_status_nxt = full ? ST_FULL : ST_INSERTED;
            out_handle_nxt = '0;
            out_action_nxt = '0;
            out_dl_nxt     = '0;
            out_last_nxt   = 1'b1;
          end
        end
      end
      S_EXPIRE: begin
        if (slot_free) begin
          if (stat[1].due) begin
            op             = OP_POP;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_FIRED;
            out_handle_nxt = handle[1];
            out_action_nxt = action[1];
            out_dl_nxt     = head_dl_ext[FIRED_DL_BITS-1:0];
            out_last_nxt   = last_fire;
            cnt_nxt        = cnt_r + CNT_W'(1);
            if (last_fire) begin
              state_nxt = S_IDLE;
            end
          end else begin
            // Nothing due at all: the request ends without a result.
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r        <= now_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_action_r <= out_action_nxt;
    out_dl_r     <= out_dl_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_dl_r, out_action_r, out_handle_r});

endmodule : deadline_ordered_timer_queue
`default_nettype wire
